FILE: hw/rtl/offset_coordinate_hasher_unit_assert.svh
// Assertion macros shared by the offset coordinate hasher RTL.
`ifndef OFFSET_COORDINATE_HASHER_UNIT_ASSERT_SVH
`define OFFSET_COORDINATE_HASHER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OCH_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/och_pkg.sv
// Types, constants and the FNV-1a round shared by the offset coordinate hasher.
`timescale 1ns / 1ps
`default_nettype none

package och_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

    localparam int IN_DATA_W   = 232;
    localparam int OUT_DATA_W  = 72;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    // Power of two, so the queue pointers wrap by themselves.
    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_HASH = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OFFSETS_IN_USE = 8'd0,
        REG_HASH_ONLY_MODE = 8'd1
    } cfg_reg_t;

    // Input tdata, lowest field last.
    typedef struct packed {
        logic [2:0]  pad;
        logic [31:0] coord_z;
        logic [31:0] coord_y;
        logic [31:0] coord_x;
        logic [31:0] batch_index;
        logic [31:0] offset_dz;
        logic [31:0] offset_dy;
        logic [31:0] offset_dx;
        logic [4:0]  entry_index;
    } in_data_t;

    // Output tdata, lowest field last.
    typedef struct packed {
        logic [2:0]  pad;
        logic [4:0]  offset_number;
        logic [63:0] hash_value;
    } out_data_t;

    // One classified request between front and back.
    typedef struct packed {
        logic        is_load;
        logic [4:0]  entry_index;
        logic [31:0] offset_dx;
        logic [31:0] offset_dy;
        logic [31:0] offset_dz;
        logic [31:0] batch_index;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
        logic        final_point;
    } queue_entry_t;

    // Hash pipeline stage contents.
    typedef struct packed {
        logic [63:0] hash;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [4:0]  num;
        logic        last;
        logic        fin;
    } pipe_t;

    // One FNV-1a step: xor in the word, multiply by 2^40 + 0x1B3 mod 2^64.
    function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [31:0] w);
        logic [63:0] t;
        t = h ^ {32'd0, w};
        return (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/och_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module och_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
)
(
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/och_queue.sv
// Short request queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module och_queue
    import och_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire queue_entry_t push_entry,
    output logic              ready,
    output logic              head_valid,
    output queue_entry_t      head,
    input  wire logic         pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t   slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = NW'(count_reg + 1'b1);
            2'b01:   count_next = NW'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign ready      = (count_reg != NW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: hw/rtl/och_front.sv
// Front part: accept input requests, classify them and queue the ones with work.
`timescale 1ns / 1ps
`default_nettype none

module och_front
    import och_pkg::*;
#(
    parameter int MAX_OFFSETS = 32
)
(
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tlast,
    input  wire logic [0:0]           s_axis_tuser,
    input  wire logic                 q_ready,
    output logic                      push,
    output queue_entry_t              push_entry
);

    in_data_t d;
    logic     accept;
    logic     is_load;
    logic     in_range;

    assign d        = in_data_t'(s_axis_tdata);
    assign is_load  = (s_axis_tuser[0] == CMD_LOAD);
    assign in_range = ({27'd0, d.entry_index} < 32'(MAX_OFFSETS));

    assign s_axis_tready = q_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    // Drop loads beyond the table here; they never reach the back part.
    assign push          = accept && (!is_load || in_range);

    always_comb
    begin
        push_entry.is_load     = is_load;
        push_entry.entry_index = d.entry_index;
        push_entry.offset_dx   = d.offset_dx;
        push_entry.offset_dy   = d.offset_dy;
        push_entry.offset_dz   = d.offset_dz;
        push_entry.batch_index = d.batch_index;
        push_entry.coord_x     = d.coord_x;
        push_entry.coord_y     = d.coord_y;
        push_entry.coord_z     = d.coord_z;
        push_entry.final_point = s_axis_tlast;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/och_back.sv
// Back part: offset table, entry sequencer and four-round FNV-1a pipeline.
`timescale 1ns / 1ps
`default_nettype none

module och_back
    import och_pkg::*;
#(
    parameter int MAX_OFFSETS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire queue_entry_t          head,
    output logic                       pop,
    input  wire logic [5:0]            offsets_in_use,
    input  wire logic                  hash_only_mode,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    output logic [0:0]                 m_axis_tuser
);

    localparam int CW = $clog2(MAX_OFFSETS + 1);
    localparam int IW = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;

    logic                   adv;
    logic                   issue;
    logic                   issue_hash;
    logic                   k_last;
    logic [CW-1:0]          run_len;
    logic [CW-1:0]          k_reg, k_next;
    logic [CW+4:0]          k_ext;
    logic [IW+4:0]          widx_ext;
    logic [IW-1:0]          raddr;
    logic [IW-1:0]          waddr;
    logic                   we;
    logic [95:0]            rd_data;
    logic [95:0]            off;
    logic [MAX_OFFSETS-1:0] valid_reg;

    logic                   s1_valid_reg;
    logic                   s1_use_off_reg;
    logic [31:0]            s1_b_reg, s1_x_reg, s1_y_reg, s1_z_reg;
    logic [4:0]             s1_num_reg;
    logic                   s1_last_reg, s1_fin_reg;

    logic                   s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    pipe_t                  s2_next, s2_reg;
    pipe_t                  s3_next, s3_reg;
    pipe_t                  s4_next, s4_reg;
    pipe_t                  out_next, out_reg;

    // Stall every stage together while the output register is held.
    assign adv        = !out_valid_reg || m_axis_tready;
    assign issue      = adv && head_valid;
    assign issue_hash = issue && !head.is_load;
    assign we         = issue && head.is_load;

    always_comb
    begin
        if (hash_only_mode)
        begin
            run_len = CW'(1);
        end
        else if (offsets_in_use == 6'd0)
        begin
            run_len = CW'(1);
        end
        else if (int'(offsets_in_use) > MAX_OFFSETS)
        begin
            run_len = CW'(MAX_OFFSETS);
        end
        else
        begin
            run_len = CW'(offsets_in_use);
        end
    end

    assign k_last   = (CW'(k_reg + 1'b1) == run_len);
    assign k_ext    = (CW + 5)'(k_reg);
    assign raddr    = k_reg[IW-1:0];
    assign widx_ext = (IW + 5)'(head.entry_index);
    assign waddr    = widx_ext[IW-1:0];
    assign pop      = issue && (head.is_load || k_last);

    always_comb
    begin
        k_next = k_reg;
        if (issue_hash)
        begin
            k_next = k_last ? '0 : CW'(k_reg + 1'b1);
        end
    end

    och_ram #(
        .WIDTH (96),
        .DEPTH (MAX_OFFSETS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({head.offset_dz, head.offset_dy, head.offset_dx}),
        .re    (issue_hash),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (adv)
            begin
                s1_valid_reg  <= issue_hash;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Entry never loaded reads as zero; raw coordinate in hash-only mode.
    always_ff @(posedge clk)
    begin
        if (issue_hash)
        begin
            s1_use_off_reg <= valid_reg[raddr] && !hash_only_mode;
            s1_b_reg       <= head.batch_index;
            s1_x_reg       <= head.coord_x;
            s1_y_reg       <= head.coord_y;
            s1_z_reg       <= head.coord_z;
            s1_num_reg     <= k_ext[4:0];
            s1_last_reg    <= k_last;
            s1_fin_reg     <= k_last && head.final_point;
        end
    end

    always_comb
    begin
        off           = s1_use_off_reg ? rd_data : '0;
        s2_next.hash  = fnv_round(FNV_BASIS, s1_b_reg);
        s2_next.x     = s1_x_reg + off[31:0];
        s2_next.y     = s1_y_reg + off[63:32];
        s2_next.z     = s1_z_reg + off[95:64];
        s2_next.num   = s1_num_reg;
        s2_next.last  = s1_last_reg;
        s2_next.fin   = s1_fin_reg;

        s3_next       = s2_reg;
        s3_next.hash  = fnv_round(s2_reg.hash, s2_reg.x);

        s4_next       = s3_reg;
        s4_next.hash  = fnv_round(s3_reg.hash, s3_reg.y);

        out_next      = s4_reg;
        out_next.hash = fnv_round(s4_reg.hash, s4_reg.z);
    end

    // One round per stage; the z round lands in the output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_t'{pad: 3'd0, offset_number: out_reg.num,
                                         hash_value: out_reg.hash};
    assign m_axis_tlast    = out_reg.last;
    assign m_axis_tuser[0] = out_reg.fin;

endmodule

`default_nettype wire

FILE: hw/rtl/offset_coordinate_hasher_unit.sv
// Top level of the offset coordinate hasher: config registers, front, queue and back.
//
// Input stream (s_axis): one request per transfer. tuser is the command: load writes one
// (dx, dy, dz) entry of the offset table and gives no result; hash takes one coordinate
// (batch, x, y, z) with tlast marking the last point of a batch.
// Output stream (m_axis): one 64-bit FNV-1a hash per table entry in use, in entry order,
// with the entry number beside it; tlast marks the last hash of a coordinate and tuser
// repeats the input tlast on that hash only. Hash-only mode gives one hash of the raw
// coordinate with entry number zero.
// Config channel: cfg_index 0 sets offsets in use (0 acts as 1, capped at MAX_OFFSETS),
// cfg_index 1 sets hash-only mode. Write only while the block is idle.
// The back part issues one table entry per cycle through the single RAM read port while
// the output is not stalled; a hash request stays at the queue head until every entry in
// use (one in hash-only mode) has issued, and a load leaves once its entry is written.
// Reset: offset table reads as all zero, offsets in use = 1, hash-only mode off.
// A stalled receiver holds the output register and freezes the pipeline; the two-entry
// queue keeps taking requests until it fills.
`timescale 1ns / 1ps
`default_nettype none
`include "offset_coordinate_hasher_unit_assert.svh"

module offset_coordinate_hasher_unit
    import och_pkg::*;
#(
    parameter int MAX_OFFSETS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // entry_index, offset_dx, offset_dy, offset_dz, batch_index, coord_x, coord_y, coord_z
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                   s_axis_tlast,   // final_point
    input  wire logic [0:0]             s_axis_tuser,   // command
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // hash_value, offset_number
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                        m_axis_tlast,   // last_of_run
    output logic [0:0]                  m_axis_tuser,   // batch_end
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [5:0]   offsets_in_use_reg, offsets_in_use_next;
    logic         hash_only_mode_reg, hash_only_mode_next;
    logic         q_push;
    logic         q_ready;
    logic         q_pop;
    logic         q_head_valid;
    queue_entry_t q_push_entry;
    queue_entry_t q_head;

    // Config writes are registered directly; unknown indexes fall through.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        offsets_in_use_next = offsets_in_use_reg;
        hash_only_mode_next = hash_only_mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_OFFSETS_IN_USE: offsets_in_use_next = cfg_data[5:0];
                REG_HASH_ONLY_MODE: hash_only_mode_next = cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offsets_in_use_reg <= 6'd1;
            hash_only_mode_reg <= 1'b0;
        end
        else
        begin
            offsets_in_use_reg <= offsets_in_use_next;
            hash_only_mode_reg <= hash_only_mode_next;
        end
    end

    // Classify and drop out-of-range loads before queuing.
    och_front #(
        .MAX_OFFSETS (MAX_OFFSETS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .q_ready       (q_ready),
        .push          (q_push),
        .push_entry    (q_push_entry)
    );

    och_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .ready      (q_ready),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    // Apply loads in order and expand hash requests into one hash per entry in use.
    och_back #(
        .MAX_OFFSETS (MAX_OFFSETS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_head_valid),
        .head           (q_head),
        .pop            (q_pop),
        .offsets_in_use (offsets_in_use_reg),
        .hash_only_mode (hash_only_mode_reg),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser)
    );

    `OCH_ASSERT_IMPLY(a_pop_nonempty, q_pop, q_head_valid, "back popped an empty queue")
    `OCH_ASSERT_IMPLY(a_push_room, q_push, q_ready, "front pushed into a full queue")
    `OCH_ASSERT_NEXT(a_push_visible, q_push && !q_pop, q_head_valid, "pushed request lost")
    `OCH_ASSERT_IMPLY(a_end_on_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "stray end")

endmodule

`default_nettype wire

FILE: test/offset_coordinate_hasher_unit_tb.sv
// Testbench for offset_coordinate_hasher_unit: directed and random requests, FNV-1a predictor.
`timescale 1ns / 1ps

module offset_coordinate_hasher_unit_tb;
    import och_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam int          MAX_OFFSETS   = 32;
    localparam int          CYCLE_LIMIT   = 2_000_000;
    // Cycles to let a load (no result) clear the queue and the pipeline.
    localparam int          SETTLE_CYCLES = 16;
    localparam int          RANDOM_PHASES = 13;
    localparam int          PHASE_ITEMS   = 20;
    localparam logic [63:0] HASH_BASIS    = 64'hCBF29CE484222325;
    localparam logic [63:0] HASH_PRIME    = 64'd1099511628211;
    // First register index with nothing behind it.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd2;

    // One request as the sender sees it; unused fields carry noise.
    typedef struct {
        logic        cmd;
        logic [4:0]  entry;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
        logic [31:0] b;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        fin;
    } request_t;

    // One hash the block must emit.
    typedef struct packed {
        logic [63:0] hash;
        logic [4:0]  entry;
        logic        last;
        logic        batch_end;
    } hash_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic [0:0]             m_axis_tuser;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // Predictor state: offset table and the two registers as the block holds them.
    logic [31:0]  table_dx [MAX_OFFSETS];
    logic [31:0]  table_dy [MAX_OFFSETS];
    logic [31:0]  table_dz [MAX_OFFSETS];
    logic [5:0]   offsets_reg;
    logic         hash_only_reg;

    hash_result_t pending_hashes[$];

    // Steady flow: no gaps from the sender, no stalls from the receiver.
    bit           steady_flow = 1'b0;
    int           ready_run   = 0;
    int           cycle_count = 0;
    int           error_count = 0;
    int           loads_sent  = 0;
    int           hashes_sent = 0;
    int           hashes_seen = 0;
    int           reg_writes  = 0;

    offset_coordinate_hasher_unit #(
        .MAX_OFFSETS (MAX_OFFSETS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d hashes outstanding",
                     cycle_count, pending_hashes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Random lengths and words
    // ------------------------------------------------------------------

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 30);
    endfunction

    function automatic int sender_gap();
        if (steady_flow || $urandom_range(0, 1) == 0)
            return 0;
        return idle_length();
    endfunction

    // Bias toward the sign and wrap corners of a 32-bit word.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t hash_request(input logic [31:0] b, input logic [31:0] x,
                                              input logic [31:0] y, input logic [31:0] z,
                                              input logic fin);
        request_t req;
        req.cmd   = CMD_HASH;
        req.entry = 5'($urandom_range(0, MAX_OFFSETS - 1));
        req.dx    = $urandom;
        req.dy    = $urandom;
        req.dz    = $urandom;
        req.b     = b;
        req.x     = x;
        req.y     = y;
        req.z     = z;
        req.fin   = fin;
        return req;
    endfunction

    function automatic request_t load_request(input logic [4:0] entry, input logic [31:0] dx,
                                              input logic [31:0] dy, input logic [31:0] dz);
        request_t req;
        req       = hash_request($urandom, $urandom, $urandom, $urandom,
                                 1'($urandom_range(0, 1)));
        req.cmd   = CMD_LOAD;
        req.entry = entry;
        req.dx    = dx;
        req.dy    = dy;
        req.dz    = dz;
        return req;
    endfunction

    function automatic request_t random_hash();
        return hash_request(rand_word(), rand_word(), rand_word(), rand_word(),
                            1'($urandom_range(0, 1)));
    endfunction

    function automatic request_t random_load();
        return load_request(5'($urandom_range(0, MAX_OFFSETS - 1)), rand_word(), rand_word(),
                            rand_word());
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // FNV-1a over batch, x, y, z: xor each word in, multiply by the prime mod 2^64.
    function automatic logic [63:0] coord_hash(input logic [31:0] b, input logic [31:0] x,
                                               input logic [31:0] y, input logic [31:0] z);
        logic [63:0] h;
        h = HASH_BASIS;
        h = (h ^ {32'd0, b}) * HASH_PRIME;
        h = (h ^ {32'd0, x}) * HASH_PRIME;
        h = (h ^ {32'd0, y}) * HASH_PRIME;
        h = (h ^ {32'd0, z}) * HASH_PRIME;
        return h;
    endfunction

    // Entries applied per coordinate: zero acts as one, above the table saturates.
    function automatic int active_offsets();
        if (offsets_reg == 0)
            return 1;
        if (offsets_reg > MAX_OFFSETS)
            return MAX_OFFSETS;
        return int'(offsets_reg);
    endfunction

    // Apply one accepted request: update the table or queue up its hashes.
    task automatic predict_request(input request_t req);
        hash_result_t res;
        int           count;
        if (req.cmd == CMD_LOAD)
        begin
            loads_sent++;
            if (req.entry < MAX_OFFSETS)
            begin
                table_dx[req.entry] = req.dx;
                table_dy[req.entry] = req.dy;
                table_dz[req.entry] = req.dz;
            end
        end
        else
        begin
            hashes_sent++;
            if (hash_only_reg)
            begin
                res.hash      = coord_hash(req.b, req.x, req.y, req.z);
                res.entry     = '0;
                res.last      = 1'b1;
                res.batch_end = req.fin;
                pending_hashes.push_back(res);
            end
            else
            begin
                count = active_offsets();
                for (int k = 0; k < count; k++)
                begin
                    res.hash      = coord_hash(req.b, req.x + table_dx[k], req.y + table_dy[k],
                                               req.z + table_dz[k]);
                    res.entry     = k[4:0];
                    res.last      = (k == count - 1);
                    res.batch_end = (k == count - 1) ? req.fin : 1'b0;
                    pending_hashes.push_back(res);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Send one request. Enter and leave just after a rising edge; valid stays high
    // on exit so that a back-to-back request does not drop it.
    task automatic send_request(input request_t req);
        in_data_t word;
        int       gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word             = '0;
        word.entry_index = req.entry;
        word.offset_dx   = req.dx;
        word.offset_dy   = req.dy;
        word.offset_dz   = req.dz;
        word.batch_index = req.b;
        word.coord_x     = req.x;
        word.coord_y     = req.y;
        word.coord_z     = req.z;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= req.fin;
        s_axis_tuser  <= req.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_request(req);
    endtask

    // Hold the sender until every expected hash is out and any trailing load is done.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; call only while the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (index == REG_OFFSETS_IN_USE)
            offsets_reg = value[5:0];
        else if (index == REG_HASH_ONLY_MODE)
            hash_only_reg = value[0];
        // Separate back-to-back writes so valid never drops and rises in one step.
        @(posedge clk);
    endtask

    // Receiver: alternate ready runs and stalls of random length.
    always @(posedge clk)
    begin
        if (ready_run > 0)
            ready_run <= ready_run - 1;
        else if (steady_flow)
        begin
            m_axis_tready <= 1'b1;
            ready_run     <= 4;
        end
        else if ($urandom_range(0, 9) < 6)
        begin
            m_axis_tready <= 1'b1;
            ready_run     <= $urandom_range(0, 11);
        end
        else
        begin
            m_axis_tready <= 1'b0;
            ready_run     <= idle_length() - 1;
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Compare each hash taken by the receiver with the oldest expectation.
    always @(posedge clk)
    begin
        out_data_t    got;
        hash_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_hashes.size() == 0)
                flag_mismatch("hash with none expected", got.hash_value, '0);
            else
            begin
                want = pending_hashes.pop_front();
                hashes_seen++;
                if (got.hash_value !== want.hash)
                    flag_mismatch("hash_value", got.hash_value, want.hash);
                if (got.offset_number !== want.entry)
                    flag_mismatch("offset_number", 64'(got.offset_number), 64'(want.entry));
                if (m_axis_tlast !== want.last)
                    flag_mismatch("last_of_run", 64'(m_axis_tlast), 64'(want.last));
                if (m_axis_tuser[0] !== want.batch_end)
                    flag_mismatch("batch_end", 64'(m_axis_tuser[0]), 64'(want.batch_end));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset state: one entry in use, table all zero, so each hash is of the raw coordinate.
    task automatic test_reset_state();
        send_request(hash_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                                  32'h0000_0000, 1'b0));
        send_request(hash_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 1'b1));
        send_request(hash_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 1'b1));
        send_request(hash_request(32'd1, 32'd2, 32'd3, 32'd4, 1'b0));
    endtask

    // Load the end entries with extreme offsets and hash across the full table,
    // so that x, y and z wrap in both directions.
    task automatic test_offset_table();
        send_request(load_request(5'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000));
        send_request(load_request(5'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(load_request(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(load_request(5'd15, $urandom, $urandom, $urandom));
        wait_idle();
        write_reg(REG_OFFSETS_IN_USE, 8'd32);
        send_request(hash_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 1'b1));
        send_request(hash_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000,
                                  32'h8000_0000, 1'b0));
        wait_idle();
        write_reg(REG_OFFSETS_IN_USE, 8'd2);
        send_request(hash_request(32'd7, 32'hFFFF_FFFF, 32'h0000_0001, 32'd0, 1'b1));
    endtask

    // Register corners: zero entries, masked and saturated counts, unmapped indexes,
    // and hash-only mode with a load that must stay silent.
    task automatic test_register_corners();
        wait_idle();
        write_reg(REG_OFFSETS_IN_USE, 8'd0);
        send_request(random_hash());
        wait_idle();
        write_reg(REG_OFFSETS_IN_USE, 8'hFF);
        send_request(random_hash());
        wait_idle();
        write_reg(REG_OFFSETS_IN_USE, 8'd33);
        send_request(random_hash());
        wait_idle();
        write_reg(REG_OFFSETS_IN_USE, 8'd3);
        write_reg(REG_UNMAPPED, 8'd7);
        write_reg(8'hFF, 8'hFF);
        send_request(random_hash());
        wait_idle();
        write_reg(REG_HASH_ONLY_MODE, 8'h03);
        send_request(hash_request(32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd5, 1'b0));
        send_request(load_request(5'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1));
        send_request(hash_request(32'd9, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1));
        wait_idle();
        // Bit 0 clear turns the mode off; entry 2 now holds the new offsets.
        write_reg(REG_HASH_ONLY_MODE, 8'h02);
        send_request(random_hash());
    endtask

    // Random phases, each under its own register setting: a few loads first, then
    // mostly hashes with loads mixed in to change the table under traffic.
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] count_value;
        logic [CFG_DATA_W-1:0] mode_value;
        int                    first_loads;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: count_value = 8'($urandom_range(1, 8));
                6:                count_value = 8'($urandom_range(9, 31));
                7:                count_value = 8'(MAX_OFFSETS);
                8:                count_value = 8'($urandom_range(0, 255));
                default:          count_value = ($urandom_range(0, 1) == 0) ? 8'd0
                                                : 8'($urandom_range(33, 63));
            endcase
            mode_value    = 8'($urandom_range(0, 255));
            mode_value[0] = ($urandom_range(0, 3) == 0);
            write_reg(REG_OFFSETS_IN_USE, count_value);
            write_reg(REG_HASH_ONLY_MODE, mode_value);
            if ($urandom_range(0, 4) == 0)
                write_reg(8'($urandom_range(REG_UNMAPPED, {CFG_INDEX_W{1'b1}})),
                          8'($urandom));
            steady_flow = ($urandom_range(0, 4) == 0);
            first_loads = $urandom_range(0, 4);
            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                // Once mid-run, hold the sender until the output side has drained.
                if (phase == RANDOM_PHASES / 2 && item == PHASE_ITEMS / 2)
                    wait_idle();
                if (item < first_loads || $urandom_range(0, 99) < 15)
                    send_request(random_load());
                else
                    send_request(random_hash());
            end
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        for (int k = 0; k < MAX_OFFSETS; k++)
        begin
            table_dx[k] = '0;
            table_dy[k] = '0;
            table_dz[k] = '0;
        end
        offsets_reg   = 6'd1;
        hash_only_reg = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_offset_table();
        test_register_corners();
        test_random_traffic();

        // Drain the output side, then allow the pipeline latency to expose strays.
        wait_idle();

        $display("Sent %0d hash and %0d load requests across %0d register writes;",
                 hashes_sent, loads_sent, reg_writes);
        $display("checked %0d hashes, %0d errors", hashes_seen, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
